/* sv/qas_pkg.sv */
// Shared types and constants for the quoted argument splitter.
`default_nettype none

package qas_pkg;

    localparam int unsigned MAX_ARGS_DEF = 64;
    localparam int unsigned IDX_CAP      = 64;

    localparam int unsigned KIND_W  = 2;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned IDX_W   = 6;
    localparam int unsigned TOTAL_W = 7;
    localparam int unsigned RES_N   = 3;
    localparam int unsigned CNT_W   = 2;

    localparam logic [KIND_W-1:0] K_BYTE    = 2'd0;
    localparam logic [KIND_W-1:0] K_ENDARG  = 2'd1;
    localparam logic [KIND_W-1:0] K_ENDLINE = 2'd2;

    localparam logic [0:0] CFG_MAX_ARGS   = 1'b0;
    localparam logic [0:0] CFG_QUOTE_MODE = 1'b1;

    localparam logic [TOTAL_W-1:0] MAX_ARGS_RST   = 7'd64;
    localparam logic               QUOTE_MODE_RST = 1'b1;

    localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;
    localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
    localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CH_QUOTE = 8'h22;
    localparam logic [BYTE_W-1:0] CH_BSLASH = 8'h5C;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [BYTE_W-1:0]  out_byte;
        logic [IDX_W-1:0]   arg_index;
        logic [TOTAL_W-1:0] arg_total;
    } t_res;

    typedef struct packed {
        t_res [RES_N-1:0] ent;
        logic [CNT_W-1:0] cnt;
    } t_res_set;

endpackage

`default_nettype wire

/* sv/quoted_argument_splitter.sv */
// Top level of the quoted argument splitter: config registers, scan and result buffer.
//
//  channel  direction  handshake               payload
//  in       input      i_in_valid/o_in_stall   i_in_byte
//  out      output     o_out_valid/i_out_stall o_kind o_out_byte o_arg_index o_arg_total o_last
//  cfg      input      i_cfg_valid/o_cfg_ready i_cfg_index i_cfg_data
//
// One byte per cycle when each byte yields at most one result and the output does not stall;
// a byte that yields more holds the scan stage while the single result port of the buffer
// hands them out. Each byte is registered in the scan stage and its results in the buffer.
// Synchronous active-low reset clears the scan state, argument count and buffer.
// A stalled result holds the buffer; the input stalls while a byte waits and the buffer cannot take its results.
`default_nettype none

module quoted_argument_splitter
    import qas_pkg::*;
#(
    parameter int unsigned MAX_ARGS = MAX_ARGS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic [BYTE_W-1:0]  i_in_byte,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic [KIND_W-1:0]       o_kind,
    output logic [BYTE_W-1:0]       o_out_byte,
    output logic [IDX_W-1:0]        o_arg_index,
    output logic [TOTAL_W-1:0]      o_arg_total,
    output logic                    o_last,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [0:0]         i_cfg_index,
    input  wire logic [TOTAL_W-1:0] i_cfg_data
);

    logic [TOTAL_W-1:0] r_max_args;
    logic               r_quote_mode;
    logic               buf_free;
    logic               load;
    t_res_set           res;
    t_res               head;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_args   <= MAX_ARGS_RST;
            r_quote_mode <= QUOTE_MODE_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_MAX_ARGS:   r_max_args   <= i_cfg_data;
                CFG_QUOTE_MODE: r_quote_mode <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    qas_scan #(
        .MAX_ARGS (MAX_ARGS)
    ) u_scan (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_in_byte    (i_in_byte),
        .i_max_args   (r_max_args),
        .i_quote_mode (r_quote_mode),
        .i_buf_free   (buf_free),
        .o_load       (load),
        .o_res        (res)
    );

    qas_outbuf u_outbuf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (load),
        .i_res       (res),
        .o_free      (buf_free),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_head      (head),
        .o_last      (o_last)
    );

    assign o_kind      = head.kind;
    assign o_out_byte  = head.out_byte;
    assign o_arg_index = head.arg_index;
    assign o_arg_total = head.arg_total;

    a_empty_no_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> !o_in_stall)
        else $error("input stalled with empty result buffer");

    a_endline_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_kind == K_ENDLINE) |-> o_last)
        else $error("line end is not the final result of its byte");

    a_mark_no_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_kind != K_BYTE) |-> (o_out_byte == '0))
        else $error("end mark carries a byte");

    a_total_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_kind == K_ENDLINE) |-> (o_arg_total <= TOTAL_W'(IDX_CAP)))
        else $error("argument count beyond limit");

endmodule

`default_nettype wire

/* sv/qas_scan.sv */
// Input register, scan state machine and per-byte result decode.
`default_nettype none

module qas_scan
    import qas_pkg::*;
#(
    parameter int unsigned MAX_ARGS = MAX_ARGS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic [BYTE_W-1:0]  i_in_byte,
    input  wire logic [TOTAL_W-1:0] i_max_args,
    input  wire logic               i_quote_mode,
    input  wire logic               i_buf_free,
    output logic                    o_load,
    output t_res_set                o_res
);

    localparam int unsigned LIM_CAP_I = (MAX_ARGS < IDX_CAP) ? MAX_ARGS : IDX_CAP;
    localparam logic [TOTAL_W-1:0] LIM_CAP = TOTAL_W'(LIM_CAP_I);

    localparam logic [2:0] ST_SKIP   = 3'd0;
    localparam logic [2:0] ST_WORD   = 3'd1;
    localparam logic [2:0] ST_QUOTED = 3'd2;
    localparam logic [2:0] ST_ESCAPE = 3'd3;

    logic               r_in_valid;
    logic [BYTE_W-1:0]  r_in_byte;
    logic [2:0]         r_state;
    logic [2:0]         n_state;
    logic [TOTAL_W-1:0] r_found;
    logic [TOTAL_W-1:0] n_found;

    logic               adv;
    logic               take;
    logic               blank;
    logic [IDX_W-1:0]   cur_idx;
    logic [TOTAL_W-1:0] lim;
    t_res_set           res;

    assign adv        = r_in_valid && i_buf_free;
    assign o_in_stall = r_in_valid && !i_buf_free;
    assign take       = i_in_valid && !o_in_stall;
    assign o_load     = adv;
    assign o_res      = res;

    assign blank   = (r_in_byte == CH_SPACE) || (r_in_byte == CH_TAB);
    assign cur_idx = IDX_W'(r_found - TOTAL_W'(1));
    assign lim     = (i_max_args > LIM_CAP) ? LIM_CAP : i_max_args;

    always_comb begin
        res     = '0;
        n_state = r_state;
        n_found = r_found;
        case (r_state)
            ST_WORD, ST_QUOTED: begin
                if (r_in_byte == CH_NUL) begin
                    res.ent[0].kind      = K_ENDARG;
                    res.ent[0].arg_index = cur_idx;
                    res.ent[1].kind      = K_ENDLINE;
                    res.ent[1].arg_total = r_found;
                    res.cnt              = 2'd2;
                    n_state              = ST_SKIP;
                    n_found              = '0;
                end else if ((r_state == ST_WORD && blank) ||
                             (r_state == ST_QUOTED && r_in_byte == CH_QUOTE)) begin
                    res.ent[0].kind      = K_ENDARG;
                    res.ent[0].arg_index = cur_idx;
                    res.cnt              = 2'd1;
                    n_state              = ST_SKIP;
                end else if (r_state == ST_QUOTED && r_in_byte == CH_BSLASH) begin
                    n_state = ST_ESCAPE;
                end else begin
                    res.ent[0].kind      = K_BYTE;
                    res.ent[0].out_byte  = r_in_byte;
                    res.ent[0].arg_index = cur_idx;
                    res.cnt              = 2'd1;
                end
            end
            ST_ESCAPE: begin
                res.ent[0].kind      = K_BYTE;
                res.ent[0].arg_index = cur_idx;
                if (r_in_byte == CH_NUL) begin
                    res.ent[0].out_byte  = CH_BSLASH;
                    res.ent[1].kind      = K_ENDARG;
                    res.ent[1].arg_index = cur_idx;
                    res.ent[2].kind      = K_ENDLINE;
                    res.ent[2].arg_total = r_found;
                    res.cnt              = 2'd3;
                    n_state              = ST_SKIP;
                    n_found              = '0;
                end else begin
                    res.ent[0].out_byte = r_in_byte;
                    res.cnt             = 2'd1;
                    n_state             = ST_QUOTED;
                end
            end
            default: begin
                n_state = ST_SKIP;
                if (r_in_byte == CH_NUL) begin
                    res.ent[0].kind      = K_ENDLINE;
                    res.ent[0].arg_total = r_found;
                    res.cnt              = 2'd1;
                    n_found              = '0;
                end else if (!blank && r_found < lim) begin
                    n_found = r_found + TOTAL_W'(1);
                    if (i_quote_mode && r_in_byte == CH_QUOTE) begin
                        n_state = ST_QUOTED;
                    end else begin
                        res.ent[0].kind      = K_BYTE;
                        res.ent[0].out_byte  = r_in_byte;
                        res.ent[0].arg_index = IDX_W'(r_found);
                        res.cnt              = 2'd1;
                        n_state              = ST_WORD;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_state    <= ST_SKIP;
            r_found    <= '0;
        end else begin
            if (take) begin
                r_in_valid <= 1'b1;
            end else if (adv) begin
                r_in_valid <= 1'b0;
            end
            if (adv) begin
                r_state <= n_state;
                r_found <= n_found;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_in_byte <= i_in_byte;
        end
    end

endmodule

`default_nettype wire

/* sv/qas_outbuf.sv */
// Result buffer that holds the results of one byte and hands them out in order.
`default_nettype none

module qas_outbuf
    import qas_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_load,
    input  wire t_res_set i_res,
    output logic          o_free,
    output logic          o_out_valid,
    input  wire logic     i_out_stall,
    output t_res          o_head,
    output logic          o_last
);

    logic [CNT_W-1:0] r_cnt;
    t_res [RES_N-1:0] r_ent;
    logic             pop;

    assign o_out_valid = (r_cnt != '0);
    assign pop         = o_out_valid && !i_out_stall;
    assign o_free      = (r_cnt == '0) || (r_cnt == CNT_W'(1) && !i_out_stall);
    assign o_head      = r_ent[0];
    assign o_last      = (r_cnt == CNT_W'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_load) begin
            r_cnt <= i_res.cnt;
        end else if (pop) begin
            r_cnt <= r_cnt - CNT_W'(1);
        end
    end

    // advance the queue by one entry on each take
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_ent <= i_res.ent;
        end else if (pop) begin
            r_ent[0] <= r_ent[1];
            r_ent[1] <= r_ent[2];
        end
    end

endmodule

`default_nettype wire

/* test/qas_checker.sv */
// Checker for the quoted argument splitter: predicts every result and compares it.
`timescale 1ns / 1ps

module qas_checker
    import qas_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    input  wire logic               i_in_stall,
    input  wire logic [BYTE_W-1:0]  i_in_byte,
    input  wire logic               i_out_valid,
    input  wire logic               i_out_stall,
    input  wire logic [KIND_W-1:0]  i_kind,
    input  wire logic [BYTE_W-1:0]  i_out_byte,
    input  wire logic [IDX_W-1:0]   i_arg_index,
    input  wire logic [TOTAL_W-1:0] i_arg_total,
    input  wire logic               i_last,
    input  wire logic               i_cfg_valid,
    input  wire logic               i_cfg_ready,
    input  wire logic [0:0]         i_cfg_index,
    input  wire logic [TOTAL_W-1:0] i_cfg_data,
    output int unsigned             o_fail_count,
    output int unsigned             o_pending
);

    typedef enum logic [2:0] {
        SCAN_SKIP,
        SCAN_WORD,
        SCAN_QUOTED,
        SCAN_ESCAPE
    } t_scan;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [BYTE_W-1:0]  data;
        logic [IDX_W-1:0]   index;
        logic [TOTAL_W-1:0] total;
        logic               last;
    } t_token;

    t_token             pending_tokens [$];
    logic [TOTAL_W-1:0] max_args;
    logic               quote_mode;
    t_scan              scan_state;
    logic [TOTAL_W-1:0] found_count;
    int unsigned        fail_count = 0;
    int unsigned        pending_count = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = pending_count;

    task automatic push_token(input logic [KIND_W-1:0] kind, input logic [BYTE_W-1:0] data,
                              input logic [IDX_W-1:0] index, input logic [TOTAL_W-1:0] total);
        pending_tokens.push_back({kind, data, index, total, 1'b0});
    endtask

    task automatic close_line();
        push_token(K_ENDLINE, CH_NUL, '0, found_count);
        found_count = '0;
        scan_state  = SCAN_SKIP;
    endtask

    task automatic scan_byte(input logic [BYTE_W-1:0] b);
        logic               blank;
        logic [IDX_W-1:0]   index;
        logic [TOTAL_W-1:0] limit;
        int                 first;
        t_token             tail;
        blank = (b == CH_SPACE) || (b == CH_TAB);
        index = IDX_W'(found_count - 1'b1);
        limit = (max_args > TOTAL_W'(MAX_ARGS_DEF)) ? TOTAL_W'(MAX_ARGS_DEF) : max_args;
        first = pending_tokens.size();
        case (scan_state)
            SCAN_WORD: begin
                if (b == CH_NUL) begin
                    push_token(K_ENDARG, CH_NUL, index, '0);
                    close_line();
                end else if (blank) begin
                    push_token(K_ENDARG, CH_NUL, index, '0);
                    scan_state = SCAN_SKIP;
                end else begin
                    push_token(K_BYTE, b, index, '0);
                end
            end
            SCAN_QUOTED: begin
                if (b == CH_NUL) begin
                    push_token(K_ENDARG, CH_NUL, index, '0);
                    close_line();
                end else if (b == CH_QUOTE) begin
                    push_token(K_ENDARG, CH_NUL, index, '0);
                    scan_state = SCAN_SKIP;
                end else if (b == CH_BSLASH) begin
                    scan_state = SCAN_ESCAPE;
                end else begin
                    push_token(K_BYTE, b, index, '0);
                end
            end
            SCAN_ESCAPE: begin
                if (b == CH_NUL) begin
                    push_token(K_BYTE, CH_BSLASH, index, '0);
                    push_token(K_ENDARG, CH_NUL, index, '0);
                    close_line();
                end else begin
                    push_token(K_BYTE, b, index, '0);
                    scan_state = SCAN_QUOTED;
                end
            end
            default: begin
                scan_state = SCAN_SKIP;
                if (b == CH_NUL) begin
                    close_line();
                end else if (!blank && found_count < limit) begin
                    index       = IDX_W'(found_count);
                    found_count = found_count + 1'b1;
                    if (quote_mode && b == CH_QUOTE) begin
                        scan_state = SCAN_QUOTED;
                    end else begin
                        push_token(K_BYTE, b, index, '0);
                        scan_state = SCAN_WORD;
                    end
                end
            end
        endcase
        if (pending_tokens.size() > first) begin
            tail      = pending_tokens.pop_back();
            tail.last = 1'b1;
            pending_tokens.push_back(tail);
        end
    endtask

    task automatic log_failure(input string what, input t_token exp, input t_token got);
        fail_count++;
        if (fail_count <= 10) begin
            $display("%0t %s: expected kind=%0d byte=%02h index=%0d total=%0d last=%0d",
                     $realtime, what, exp.kind, exp.data, exp.index, exp.total, exp.last);
            $display("%0t %s: actual   kind=%0d byte=%02h index=%0d total=%0d last=%0d",
                     $realtime, what, got.kind, got.data, got.index, got.total, got.last);
        end
    endtask

    always @(posedge i_clk) begin
        t_token seen;
        t_token want;
        if (!i_rst_n) begin
            max_args    = MAX_ARGS_RST;
            quote_mode  = QUOTE_MODE_RST;
            scan_state  = SCAN_SKIP;
            found_count = '0;
            pending_tokens.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                seen = {i_kind, i_out_byte, i_arg_index, i_arg_total, i_last};
                if (pending_tokens.size() == 0) begin
                    log_failure("result with nothing expected", '0, seen);
                end else begin
                    want = pending_tokens.pop_front();
                    if (seen !== want)
                        log_failure("result mismatch", want, seen);
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CFG_MAX_ARGS)
                    max_args = i_cfg_data;
                else
                    quote_mode = i_cfg_data[0];
            end
            if (i_in_valid && !i_in_stall)
                scan_byte(i_in_byte);
        end
        pending_count = pending_tokens.size();
    end

endmodule

/* test/testbench.sv */
// Top of the quoted argument splitter testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module testbench;
    import qas_pkg::*;

    localparam int unsigned CYCLE_LIMIT     = 200000;
    localparam int unsigned HOLD_OFF_CYCLES = 80;
    localparam int          PHASES          = 6;
    localparam logic [TOTAL_W-1:0] PHASE_MAX [PHASES] = '{7'd64, 7'd1, 7'd3, 7'd0, 7'd64, 7'd2};
    localparam logic               PHASE_QUOTE [PHASES] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    logic [BYTE_W-1:0]  i_in_byte;
    logic               o_out_valid;
    logic               i_out_stall;
    logic [KIND_W-1:0]  o_kind;
    logic [BYTE_W-1:0]  o_out_byte;
    logic [IDX_W-1:0]   o_arg_index;
    logic [TOTAL_W-1:0] o_arg_total;
    logic               o_last;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [0:0]         i_cfg_index;
    logic [TOTAL_W-1:0] i_cfg_data;
    int unsigned        fail_count;
    int unsigned        pending;

    int unsigned        cycle_count = 0;
    logic [BYTE_W-1:0]  line_bytes [$];
    logic               hold_off_armed = 1'b0;
    logic               hold_off_done  = 1'b0;

    quoted_argument_splitter i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_byte   (i_in_byte),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_kind      (o_kind),
        .o_out_byte  (o_out_byte),
        .o_arg_index (o_arg_index),
        .o_arg_total (o_arg_total),
        .o_last      (o_last),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    qas_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_in_byte    (i_in_byte),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_kind       (o_kind),
        .i_out_byte   (o_out_byte),
        .i_arg_index  (o_arg_index),
        .i_arg_total  (o_arg_total),
        .i_last       (o_last),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Receiver: stretches of random stall density, plus one long hold-off on request.
    initial begin
        int unsigned hold_left;
        int unsigned mode_left;
        int unsigned stall_pct;
        hold_left   = 0;
        mode_left   = 0;
        stall_pct   = 0;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left != 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else if (hold_off_armed && !hold_off_done) begin
                hold_off_done = 1'b1;
                hold_left     = HOLD_OFF_CYCLES - 1;
                i_out_stall  <= 1'b1;
            end else begin
                if (mode_left == 0) begin
                    case ($urandom_range(0, 2))
                        0:       stall_pct = 0;
                        1:       stall_pct = 30;
                        default: stall_pct = 75;
                    endcase
                    mode_left = $urandom_range(10, 50);
                end
                mode_left--;
                i_out_stall <= ($urandom_range(0, 99) < stall_pct);
            end
        end
    end

    function automatic logic [BYTE_W-1:0] rand_blank();
        return ($urandom_range(0, 1) == 0) ? CH_SPACE : CH_TAB;
    endfunction

    function automatic logic [BYTE_W-1:0] rand_word_byte();
        logic [BYTE_W-1:0] b;
        do
            b = BYTE_W'($urandom_range(1, 255));
        while (b == CH_SPACE || b == CH_TAB);
        return b;
    endfunction

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            line_bytes.push_back(s[i]);
    endtask

    task automatic add_line(input string s);
        add_text(s);
        line_bytes.push_back(CH_NUL);
    endtask

    task automatic add_quoted_arg(input bit closed);
        logic [BYTE_W-1:0] b;
        line_bytes.push_back(CH_QUOTE);
        repeat ($urandom_range(0, 5)) begin
            b = BYTE_W'($urandom_range(1, 255));
            if (b == CH_QUOTE || b == CH_BSLASH || $urandom_range(0, 7) == 0)
                line_bytes.push_back(CH_BSLASH);
            line_bytes.push_back(b);
        end
        if (closed)
            line_bytes.push_back(CH_QUOTE);
    endtask

    // Mostly well-formed lines; some noise and some lines broken at the end.
    task automatic add_random_line(input bit many_args);
        int unsigned shape;
        int unsigned n_args;
        bit          quoted;
        logic [BYTE_W-1:0] b;
        shape = many_args ? 2 : $urandom_range(0, 9);
        if (shape == 0) begin
            repeat ($urandom_range(1, 12)) begin
                case ($urandom_range(0, 5))
                    0:       line_bytes.push_back(CH_QUOTE);
                    1:       line_bytes.push_back(CH_BSLASH);
                    2:       line_bytes.push_back(rand_blank());
                    default: line_bytes.push_back(BYTE_W'($urandom_range(1, 255)));
                endcase
            end
            line_bytes.push_back(CH_NUL);
            return;
        end
        n_args = many_args ? $urandom_range(65, 70) : $urandom_range(0, 5);
        if ($urandom_range(0, 3) == 0)
            line_bytes.push_back(rand_blank());
        for (int a = 0; a < n_args; a++) begin
            quoted = !many_args && ($urandom_range(0, 2) == 0);
            if (quoted) begin
                add_quoted_arg(1'b1);
            end else begin
                do
                    b = rand_word_byte();
                while (b == CH_QUOTE);
                line_bytes.push_back(b);
                if (!many_args)
                    repeat ($urandom_range(0, 4))
                        line_bytes.push_back(rand_word_byte());
            end
            if (a != n_args - 1 && !(quoted && $urandom_range(0, 3) == 0))
                repeat ($urandom_range(1, 2))
                    line_bytes.push_back(rand_blank());
        end
        if (shape == 1) begin
            line_bytes.push_back(CH_SPACE);
            add_quoted_arg(1'b0);
            if ($urandom_range(0, 1) == 0)
                line_bytes.push_back(CH_BSLASH);
        end else if ($urandom_range(0, 3) == 0) begin
            line_bytes.push_back(rand_blank());
        end
        line_bytes.push_back(CH_NUL);
    endtask

    task automatic feed_bytes();
        int unsigned burst_left;
        burst_left = 0;
        while (line_bytes.size() != 0) begin
            if (burst_left == 0) begin
                if ($urandom_range(0, 3) != 0) begin
                    i_in_valid <= 1'b0;
                    repeat ($urandom_range(1, 6)) @(negedge i_clk);
                end
                burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                         : $urandom_range(1, 8);
            end
            i_in_byte  <= line_bytes.pop_front();
            i_in_valid <= 1'b1;
            @(posedge i_clk);
            while (o_in_stall) @(posedge i_clk);
            @(negedge i_clk);
            burst_left--;
        end
        i_in_valid <= 1'b0;
    endtask

    task automatic apply_setting(input logic [TOTAL_W-1:0] max_args, input logic quote_mode);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_MAX_ARGS;
        i_cfg_data  <= max_args;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_index <= CFG_QUOTE_MODE;
        i_cfg_data  <= TOTAL_W'(quote_mode);
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic settle();
        while (pending != 0) @(negedge i_clk);
        repeat (6) @(negedge i_clk);
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_byte   = CH_NUL;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_MAX_ARGS;
        i_cfg_data  = '0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        add_line("ab\tc  d");
        line_bytes.push_back(8'h01);
        line_bytes.push_back(8'hFF);
        line_bytes.push_back(CH_SPACE);
        line_bytes.push_back(8'h80);
        line_bytes.push_back(8'h7F);
        line_bytes.push_back(CH_NUL);
        add_line(" \"x \\\"y\" \"\"");
        add_line("\"ab\"cd");
        add_line("a\"b\\c");
        add_line("");
        add_line("\"ab");
        add_line("\"a\\");
        add_text("\"p q");
        feed_bytes();
        settle();

        // drop quote mode inside an open quoted argument
        apply_setting(MAX_ARGS_RST, 1'b0);
        add_line("r\" \"s");
        feed_bytes();
        settle();
        apply_setting(7'd2, 1'b1);
        add_line("a b c \"d");
        feed_bytes();
        settle();
        apply_setting(7'd0, 1'b0);
        add_line("ab c");
        feed_bytes();
        settle();

        for (int p = 0; p < PHASES; p++) begin
            apply_setting(PHASE_MAX[p], PHASE_QUOTE[p]);
            if (PHASE_MAX[p] == MAX_ARGS_RST && PHASE_QUOTE[p])
                hold_off_armed = 1'b1;
            while (line_bytes.size() < 8)
                add_random_line(1'b0);
            feed_bytes();
            settle();
        end

        repeat (10) @(negedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
